[src/lbcs_pkg.sv]
// Package for the LED bar chaser serializer: payload structs, command codes,
// register indexes, reset values and queue sizing. Depends on nothing.
package lbcs_pkg;

  // Command codes carried in the func field.
  localparam logic [2:0] FUNC_RAW       = 3'd0;
  localparam logic [2:0] FUNC_SHOW_UP   = 3'd1;
  localparam logic [2:0] FUNC_SHOW_DOWN = 3'd2;
  localparam logic [2:0] FUNC_RESET     = 3'd3;
  localparam logic [2:0] FUNC_OFF       = 3'd4;
  localparam logic [2:0] FUNC_STEP_UP   = 3'd5;
  localparam logic [2:0] FUNC_STEP_DOWN = 3'd6;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_SHOW_ENABLE   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP_INTERVAL = 1'd1;

  // Reset values and fixed patterns.
  localparam logic [15:0] STEP_INTERVAL_RESET = 16'd200;
  localparam logic [7:0]  PATTERN_UPPER = 8'hF0;
  localparam logic [7:0]  PATTERN_LOWER = 8'h0F;
  localparam logic [7:0]  PATTERN_BLANK = 8'h00;
  localparam logic [1:0]  UP_POS_RESET  = 2'd3;
  localparam logic [2:0]  LAST_BIT_POS  = 3'd7;

  // Byte queue between the front and the back.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] now_ms;
    logic [7:0]  raw_byte;
  } in_item_t;

  typedef struct packed {
    logic       ser_bit;
    logic [2:0] bit_position;
    logic       latch;
    logic [7:0] shown_pattern;
  } out_item_t;

  // One byte offered to or by the queue.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_xfer_t;

endpackage

[src/lbcs_front.sv]
// Command front end: decodes each command, updates the animation state and
// step timer, and pushes the byte to send into the queue. Uses lbcs_pkg.
module lbcs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lbcs_pkg::in_item_t         in_data_i,
  input  logic                       cfg_we_i,
  input  logic [lbcs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lbcs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                       fifo_full_i,
  output lbcs_pkg::byte_xfer_t       push_o
);

  logic        show_enable_q, show_enable_d;
  logic [15:0] interval_q, interval_d;
  logic [7:0]  bar_q, bar_d;
  logic [31:0] last_step_q, last_step_d;
  logic [1:0]  up_pos_q, up_pos_d;
  logic        up_clr_q, up_clr_d;
  logic [1:0]  dn_off_q, dn_off_d;
  logic        dn_clr_q, dn_clr_d;

  logic        xfer;
  logic [31:0] elapsed;
  logic        due;
  logic [7:0]  up_mask, dn_mask, up_next, dn_next;
  logic        emit;
  logic [7:0]  emit_byte;

  // A command is taken whenever the queue has room for its byte.
  assign in_ready_o = !fifo_full_i;
  assign xfer       = in_valid_i && in_ready_o;

  // Step timer uses wrapping subtraction.
  assign elapsed = in_data_i.now_ms - last_step_q;
  assign due     = elapsed >= {16'd0, interval_q};

  assign up_mask = 8'(8'h01 << up_pos_q);
  assign dn_mask = 8'(8'h10 << dn_off_q);
  assign up_next = up_clr_q ? (bar_q & ~up_mask) : (bar_q | up_mask);
  assign dn_next = dn_clr_q ? (bar_q & ~dn_mask) : (bar_q | dn_mask);

  // Configuration writes.
  always_comb begin
    show_enable_d = show_enable_q;
    interval_d    = interval_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        lbcs_pkg::CFG_SHOW_ENABLE:   show_enable_d = cfg_data_i[0];
        lbcs_pkg::CFG_STEP_INTERVAL: interval_d    = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Command decode and animation state update.
  always_comb begin
    bar_d       = bar_q;
    last_step_d = last_step_q;
    up_pos_d    = up_pos_q;
    up_clr_d    = up_clr_q;
    dn_off_d    = dn_off_q;
    dn_clr_d    = dn_clr_q;
    emit        = 1'b0;
    emit_byte   = lbcs_pkg::PATTERN_BLANK;
    case (in_data_i.func)
      lbcs_pkg::FUNC_RAW: begin
        emit      = 1'b1;
        emit_byte = in_data_i.raw_byte;
      end
      lbcs_pkg::FUNC_SHOW_UP: begin
        emit      = 1'b1;
        emit_byte = show_enable_q ? lbcs_pkg::PATTERN_UPPER : lbcs_pkg::PATTERN_BLANK;
      end
      lbcs_pkg::FUNC_SHOW_DOWN: begin
        emit      = 1'b1;
        emit_byte = show_enable_q ? lbcs_pkg::PATTERN_LOWER : lbcs_pkg::PATTERN_BLANK;
      end
      lbcs_pkg::FUNC_RESET: begin
        emit        = 1'b1;
        bar_d       = lbcs_pkg::PATTERN_BLANK;
        up_pos_d    = lbcs_pkg::UP_POS_RESET;
        up_clr_d    = 1'b0;
        dn_off_d    = 2'd0;
        dn_clr_d    = 1'b0;
        last_step_d = in_data_i.now_ms;
      end
      lbcs_pkg::FUNC_OFF: begin
        emit  = 1'b1;
        bar_d = lbcs_pkg::PATTERN_BLANK;
      end
      lbcs_pkg::FUNC_STEP_UP: begin
        if (due) begin
          emit        = 1'b1;
          emit_byte   = up_next;
          bar_d       = up_next;
          last_step_d = in_data_i.now_ms;
          up_pos_d    = up_pos_q - 2'd1;
          if (up_pos_q == 2'd0) begin
            up_clr_d = !up_clr_q;
          end
        end
      end
      lbcs_pkg::FUNC_STEP_DOWN: begin
        if (due) begin
          emit        = 1'b1;
          emit_byte   = dn_next;
          bar_d       = dn_next;
          last_step_d = in_data_i.now_ms;
          dn_off_d    = dn_off_q + 2'd1;
          if (dn_off_q == 2'd3) begin
            dn_clr_d = !dn_clr_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign push_o.valid = xfer && emit;
  assign push_o.data  = emit_byte;

  // State registers; the animation state moves only on a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      show_enable_q <= 1'b0;
      interval_q    <= lbcs_pkg::STEP_INTERVAL_RESET;
      bar_q         <= lbcs_pkg::PATTERN_BLANK;
      last_step_q   <= 32'd0;
      up_pos_q      <= lbcs_pkg::UP_POS_RESET;
      up_clr_q      <= 1'b0;
      dn_off_q      <= 2'd0;
      dn_clr_q      <= 1'b0;
    end else begin
      show_enable_q <= show_enable_d;
      interval_q    <= interval_d;
      if (xfer) begin
        bar_q       <= bar_d;
        last_step_q <= last_step_d;
        up_pos_q    <= up_pos_d;
        up_clr_q    <= up_clr_d;
        dn_off_q    <= dn_off_d;
        dn_clr_q    <= dn_clr_d;
      end
    end
  end

endmodule

[src/lbcs_fifo.sv]
// Short byte queue that decouples the command front end from the serializer.
// Uses lbcs_pkg for depth and transfer struct.
module lbcs_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbcs_pkg::byte_xfer_t push_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output lbcs_pkg::byte_xfer_t head_o
);

  logic [7:0] mem_q [lbcs_pkg::FifoDepth];
  logic [lbcs_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [lbcs_pkg::FifoCntW-1:0] count_q;
  logic do_push, do_pop;

  assign full_o       = count_q == lbcs_pkg::FifoCntW'(lbcs_pkg::FifoDepth);
  assign head_o.valid = count_q != '0;
  assign head_o.data  = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + lbcs_pkg::FifoCntW'(1);
        2'b01:   count_q <= count_q - lbcs_pkg::FifoCntW'(1);
        default: ;
      endcase
    end
  end

endmodule

[src/lbcs_back.sv]
// Serializer back end: takes one byte from the queue and sends it as eight
// registered bit results, most significant bit first. Uses lbcs_pkg.
module lbcs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbcs_pkg::byte_xfer_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lbcs_pkg::out_item_t  out_data_o
);

  logic       busy_q;
  logic [7:0] byte_q;
  logic [2:0] pos_q;
  logic       free;

  // The bit slot frees when idle or when the latch bit transfers.
  assign free  = !busy_q || (out_ready_i && pos_q == 3'd0);
  assign pop_o = free && head_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= lbcs_pkg::LAST_BIT_POS;
    end else if (free) begin
      busy_q <= head_i.valid;
      pos_q  <= lbcs_pkg::LAST_BIT_POS;
    end else if (out_ready_i) begin
      pos_q <= pos_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q <= head_i.data;
    end
  end

  // Result fields come straight from registers.
  assign out_valid_o                = busy_q;
  assign out_data_o.ser_bit         = byte_q[pos_q];
  assign out_data_o.bit_position    = pos_q;
  assign out_data_o.latch           = pos_q == 3'd0;
  assign out_data_o.shown_pattern   = byte_q;

endmodule

[src/led_bar_chaser_serializer_top.sv]
// Top level of the LED bar chaser serializer. Instantiates the command front
// end, the byte queue and the serializer; uses lbcs_pkg.

// A command that sends a byte produces eight results, one per cycle while the
// output is ready, so such commands are paced by the one-bit-per-cycle
// serializer. A command that sends nothing (an early step or an unused code)
// is taken without adding a byte to the queue. The front end accepts a command in
// any cycle in which the two-byte queue has room, so up to two bytes can wait
// behind the one being shifted out. Configuration writes take effect at the
// next clock edge.
module led_bar_chaser_serializer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lbcs_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lbcs_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lbcs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lbcs_pkg::CfgDataW-1:0] cfg_data_i
);

  lbcs_pkg::byte_xfer_t push, head;
  logic fifo_full, pop;

  lbcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_full_i (fifo_full),
    .push_o      (push)
  );

  lbcs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (fifo_full),
    .pop_i  (pop),
    .head_o (head)
  );

  lbcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/lbcs_checker.sv]
// Port-level checker for the LED bar chaser serializer and its bind to the
// top level. Uses lbcs_pkg for the payload types.
module lbcs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lbcs_pkg::out_item_t out_data_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The latch marks exactly the last bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.latch == (out_data_o.bit_position == 3'd0))
    else $error("latch does not match bit position");

  // The serial bit is the addressed bit of the shown byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.ser_bit ==
      out_data_o.shown_pattern[out_data_o.bit_position])
    else $error("serial bit does not match pattern");

  // After a non-final bit transfers, the next bit of the same byte follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.latch |=>
      out_valid_o && $stable(out_data_o.shown_pattern) &&
      out_data_o.bit_position == 3'($past(out_data_o.bit_position) - 3'd1))
    else $error("byte serialization broken");

endmodule

bind led_bar_chaser_serializer_top lbcs_checker u_lbcs_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for the LED bar chaser serializer: drives commands, predicts the
// serial bit stream of every byte sent and checks it. Depends on lbcs_pkg and
// led_bar_chaser_serializer_top.
module tb;
  import lbcs_pkg::*;

  localparam logic [2:0] FUNC_UNUSED = 3'd7;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_item_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_item_t out_data_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predicted block state and configuration.
  logic show_halves;
  logic [15:0] step_gap_ms;
  logic [7:0] lit_leds;
  logic [31:0] last_step_tick;
  logic [1:0] up_led;
  logic up_emptying;
  logic [1:0] down_led_ofs;
  logic down_emptying;

  // Serial bits still to come, oldest first.
  out_item_t bits_due[$];

  int fail_count = 0;
  int mismatch_count = 0;
  int cmds_with_output = 0;
  int unsigned cycle_count = 0;
  int tx_max_gap = 13;
  int rx_max_gap = 13;
  bit hold_req = 1'b0;
  logic [31:0] sim_ms;

  led_bar_chaser_serializer_top DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Queue the eight serial bits of one byte, most significant bit first.
  function automatic int queue_byte(input logic [7:0] value);
    out_item_t bit_item;
    for (int k = 7; k >= 0; k--) begin
      bit_item.ser_bit = value[k];
      bit_item.bit_position = 3'(k);
      bit_item.latch = (k == 0);
      bit_item.shown_pattern = value;
      bits_due.push_back(bit_item);
    end
    return 8;
  endfunction

  function automatic void restart_animation();
    lit_leds = PATTERN_BLANK;
    up_led = UP_POS_RESET;
    up_emptying = 1'b0;
    down_led_ofs = 2'd0;
    down_emptying = 1'b0;
  endfunction

  // Apply one command to the predicted state; returns the number of bits queued.
  function automatic int predict_cmd(input in_item_t cmd);
    logic [7:0] led_mask;
    logic [31:0] elapsed;
    int n;
    n = 0;
    elapsed = cmd.now_ms - last_step_tick;
    case (cmd.func)
      FUNC_RAW: n = queue_byte(cmd.raw_byte);
      FUNC_SHOW_UP: n = queue_byte(show_halves ? PATTERN_UPPER : PATTERN_BLANK);
      FUNC_SHOW_DOWN: n = queue_byte(show_halves ? PATTERN_LOWER : PATTERN_BLANK);
      FUNC_RESET: begin
        restart_animation();
        last_step_tick = cmd.now_ms;
        n = queue_byte(PATTERN_BLANK);
      end
      FUNC_OFF: begin
        lit_leds = PATTERN_BLANK;
        n = queue_byte(PATTERN_BLANK);
      end
      FUNC_STEP_UP: begin
        if (elapsed >= {16'd0, step_gap_ms}) begin
          last_step_tick = cmd.now_ms;
          led_mask = 8'h01 << up_led;
          lit_leds = up_emptying ? (lit_leds & ~led_mask) : (lit_leds | led_mask);
          if (up_led == 2'd0) begin
            up_led = UP_POS_RESET;
            up_emptying = ~up_emptying;
          end else begin
            up_led = up_led - 2'd1;
          end
          n = queue_byte(lit_leds);
        end
      end
      FUNC_STEP_DOWN: begin
        if (elapsed >= {16'd0, step_gap_ms}) begin
          last_step_tick = cmd.now_ms;
          led_mask = 8'h10 << down_led_ofs;
          lit_leds = down_emptying ? (lit_leds & ~led_mask) : (lit_leds | led_mask);
          if (down_led_ofs == 2'd3) begin
            down_led_ofs = 2'd0;
            down_emptying = ~down_emptying;
          end else begin
            down_led_ofs = down_led_ofs + 2'd1;
          end
          n = queue_byte(lit_leds);
        end
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  // Predict on every command transfer, then check every result transfer.
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (predict_cmd(in_data_i) > 0) cmds_with_output++;
      end
      if (out_valid_o && out_ready_i) begin
        if (bits_due.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: bit=%0b pos=%0d latch=%0b pattern=%02h",
                     out_data_o.ser_bit, out_data_o.bit_position, out_data_o.latch,
                     out_data_o.shown_pattern);
        end else begin
          want = bits_due.pop_front();
          if (want.ser_bit !== out_data_o.ser_bit ||
              want.bit_position !== out_data_o.bit_position ||
              want.latch !== out_data_o.latch ||
              want.shown_pattern !== out_data_o.shown_pattern) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: expected bit=%0b pos=%0d latch=%0b pattern=%02h,",
                        " got bit=%0b pos=%0d latch=%0b pattern=%02h"},
                       want.ser_bit, want.bit_position, want.latch, want.shown_pattern,
                       out_data_o.ser_bit, out_data_o.bit_position, out_data_o.latch,
                       out_data_o.shown_pattern);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls per result, plus one long hold-off on request.
  initial begin : receiver
    int n;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      n = $urandom_range(0, rx_max_gap);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i) && !hold_req);
      @(negedge clk_i);
    end
  end

  function automatic in_item_t mk_cmd(input logic [2:0] func, input logic [31:0] now,
                                      input logic [7:0] raw);
    in_item_t c;
    c.func = func;
    c.now_ms = now;
    c.raw_byte = raw;
    return c;
  endfunction

  // Offer one command after a random gap and hold it until its transfer.
  // Called and returning at a falling edge; valid stays high for the caller.
  task automatic send_cmd(input in_item_t cmd);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i <= cmd;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted bit has come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (bits_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SHOW_ENABLE: show_halves = val[0];
      CFG_STEP_INTERVAL: step_gap_ms = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic show, input logic [15:0] gap);
    wait_idle();
    write_cfg(CFG_SHOW_ENABLE, {15'd0, show});
    write_cfg(CFG_STEP_INTERVAL, gap);
  endtask

  // Mostly animation steps on an advancing tick, with the other commands mixed in.
  function automatic in_item_t make_random_cmd();
    in_item_t c;
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0)
      sim_ms = $urandom();
    else
      sim_ms = sim_ms + $urandom_range(0, 2 * int'(step_gap_ms) + 4);
    if (r < 35) c.func = FUNC_STEP_UP;
    else if (r < 70) c.func = FUNC_STEP_DOWN;
    else if (r < 78) c.func = FUNC_RAW;
    else if (r < 84) c.func = FUNC_SHOW_UP;
    else if (r < 88) c.func = FUNC_SHOW_DOWN;
    else if (r < 92) c.func = FUNC_RESET;
    else if (r < 97) c.func = FUNC_OFF;
    else c.func = FUNC_UNUSED;
    c.now_ms = sim_ms;
    c.raw_byte = $urandom_range(0, 255);
    return c;
  endfunction

  // Send random commands until the given number of them have produced output.
  task automatic send_random(input int count);
    int start;
    start = cmds_with_output;
    while (cmds_with_output - start < count) send_cmd(make_random_cmd());
  endtask

  // Raw bytes at the extremes, and both show commands with the halves off and on.
  task automatic test_raw_and_show();
    send_cmd(mk_cmd(FUNC_RAW, 32'd0, 8'h00));
    send_cmd(mk_cmd(FUNC_RAW, 32'd0, 8'hFF));
    send_cmd(mk_cmd(FUNC_RAW, 32'hFFFF_FFFF, 8'hA5));
    send_cmd(mk_cmd(FUNC_SHOW_UP, 32'd0, 8'hFF));
    send_cmd(mk_cmd(FUNC_SHOW_DOWN, 32'd0, 8'hFF));
    apply_settings(1'b1, STEP_INTERVAL_RESET);
    send_cmd(mk_cmd(FUNC_SHOW_UP, 32'd0, 8'h00));
    send_cmd(mk_cmd(FUNC_SHOW_DOWN, 32'd0, 8'h00));
  endtask

  task automatic test_reset_and_off();
    send_cmd(mk_cmd(FUNC_RESET, 32'd1000, 8'h3C));
    send_cmd(mk_cmd(FUNC_OFF, 32'd0, 8'hC3));
  endtask

  // Steps just before and at the interval, and across the tick wraparound.
  task automatic test_step_timing();
    send_cmd(mk_cmd(FUNC_STEP_UP, 32'd1100, 8'h00));
    send_cmd(mk_cmd(FUNC_STEP_UP, 32'd1200, 8'h00));
    send_cmd(mk_cmd(FUNC_STEP_DOWN, 32'd1399, 8'h00));
    send_cmd(mk_cmd(FUNC_STEP_DOWN, 32'd1400, 8'h00));
    send_cmd(mk_cmd(FUNC_RESET, 32'hFFFF_FF00, 8'h00));
    send_cmd(mk_cmd(FUNC_STEP_DOWN, 32'h0000_0010, 8'h00));
  endtask

  // With a zero interval every step is taken; five up steps wrap into clearing.
  task automatic test_zero_interval();
    apply_settings(1'b0, 16'd0);
    repeat (5) send_cmd(mk_cmd(FUNC_STEP_UP, 32'd0, 8'h00));
  endtask

  // Largest interval, one tick short and exactly met, then the unused code.
  task automatic test_max_interval();
    apply_settings(1'b1, 16'hFFFF);
    send_cmd(mk_cmd(FUNC_RESET, 32'd5000, 8'h00));
    send_cmd(mk_cmd(FUNC_STEP_UP, 32'd5000 + 32'd65534, 8'h00));
    send_cmd(mk_cmd(FUNC_STEP_UP, 32'd5000 + 32'd65535, 8'h00));
    send_cmd(mk_cmd(FUNC_UNUSED, $urandom(), 8'hFF));
  endtask

  // Random command mix over several settings, extremes included.
  task automatic test_random_mix();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_settings(1'b1, 16'd0);
        1: apply_settings(1'b0, 16'hFFFF);
        2: apply_settings(1'b1, 16'd1);
        3: apply_settings(1'b1, STEP_INTERVAL_RESET);
        4: apply_settings(1'b0, 16'($urandom()));
        default: apply_settings(1'b1, 16'($urandom_range(0, 500)));
      endcase
      // Start some phases just below the tick wraparound.
      sim_ms = (phase % 2 == 0) ? 32'hFFFF_F000 : $urandom();
      send_random(15);
    end
  endtask

  // Receiver holds off for a long stretch while commands keep coming.
  task automatic test_output_stall();
    apply_settings(1'b1, 16'd50);
    tx_max_gap = 0;
    hold_req = 1'b1;
    send_random(15);
    tx_max_gap = 13;
  endtask

  // Neither side idles.
  task automatic test_back_to_back();
    apply_settings(1'b0, 16'd10);
    tx_max_gap = 0;
    rx_max_gap = 0;
    send_random(25);
    wait_idle();
    tx_max_gap = 13;
    rx_max_gap = 13;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    show_halves = 1'b0;
    step_gap_ms = STEP_INTERVAL_RESET;
    last_step_tick = 32'd0;
    sim_ms = 32'd0;
    restart_animation();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_raw_and_show();
    test_reset_and_off();
    test_step_timing();
    test_zero_interval();
    test_max_interval();
    test_random_mix();
    test_output_stall();
    test_back_to_back();
    wait_idle();

    if (bits_due.size() != 0)
      $display("%0d expected results never arrived", bits_due.size());
    if (fail_count == 0 && bits_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/lbcs_pkg.sv
src/lbcs_front.sv
src/lbcs_fifo.sv
src/lbcs_back.sv
src/led_bar_chaser_serializer_top.sv
src/lbcs_checker.sv
tb/sv/tb.sv
